// File: src/wbps_pkg.sv
package wbps_pkg;

	// default sizes
	localparam int MAX_PATTERN_DEF = 16;
	localparam int POSITION_BITS_DEF = 32;

	// pattern register storage holds this many bytes
	localparam int REG_BYTES = 16;

	// configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 64;
	localparam int LEN_BITS = 5;
	localparam int START_BITS = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_WILDCARD     = 2'd2,
		REG_LENGTH       = 2'd3
	} cfg_reg_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic step;
		logic clear;
	} cell_ctrl_t;

endpackage

// File: src/wildcard_byte_pattern_scanner_unit.sv
// results are registered, in the output register or else the skid entry
// throughput: one byte item per cycle while byte_stall is low, set by the cell chain
//   holding one prefix bit per pattern byte and advancing on every accepted item
// a two-entry result buffer lets bytes keep flowing while a result waits
// reset (arst_n low): registers return to zero pattern, no wildcards, length 1,
//   empty window, position zero, no result pending
module wildcard_byte_pattern_scanner_unit #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = wbps_pkg::POSITION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// byte channel
	input  logic                                byte_valid,
	output logic                                byte_stall,
	input  logic [7:0]                          data_byte,
	input  logic                                section_end,
	input  logic                                scan_end,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                found,
	output logic [wbps_pkg::START_BITS-1:0]     match_start,
	// configuration
	input  logic                                wr_en,
	input  logic [wbps_pkg::CFG_INDEX_BITS-1:0] wr_index,
	input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  wr_data
);

	localparam int CELLS = (MAX_PATTERN < wbps_pkg::REG_BYTES) ? MAX_PATTERN
		: wbps_pkg::REG_BYTES;
	localparam int LEN_IDX_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int LB = wbps_pkg::LEN_BITS;

	// configuration registers
	logic [8*wbps_pkg::REG_BYTES-1:0] pattern_q;
	logic [wbps_pkg::REG_BYTES-1:0]   wildcard_q;
	logic [LB-1:0]                    length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			wildcard_q <= '0;
			length_q <= LB'(1);
		end else if (wr_en) begin
			case (wbps_pkg::cfg_reg_t'(wr_index))
				wbps_pkg::REG_PATTERN_LOW: begin
					pattern_q[63:0] <= wr_data;
				end
				wbps_pkg::REG_PATTERN_HIGH: begin
					pattern_q[127:64] <= wr_data;
				end
				wbps_pkg::REG_WILDCARD: begin
					wildcard_q <= wr_data[15:0];
				end
				wbps_pkg::REG_LENGTH: begin
					length_q <= wr_data[LB-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// pattern length clamped to 1..CELLS
	logic [LB-1:0]           len_eff;
	logic [LEN_IDX_BITS-1:0] len_idx;

	always_comb begin
		if (length_q == '0) begin
			len_eff = LB'(1);
		end else if (length_q > LB'(CELLS)) begin
			len_eff = LB'(CELLS);
		end else begin
			len_eff = length_q;
		end
	end
	assign len_idx = LEN_IDX_BITS'(len_eff - LB'(1));

	// handshake and scan control state
	logic                     accept;
	logic                     reported_q;
	logic [POSITION_BITS-1:0] pos_q;
	wbps_pkg::cell_ctrl_t     cell_ctrl;

	// cells advance on every item so a scan end always empties them
	assign accept = byte_valid & ~byte_stall;
	assign cell_ctrl.step = accept;
	assign cell_ctrl.clear = section_end | scan_end;

	// chain of prefix cells
	logic [CELLS-1:0] next_vec;
	logic [CELLS-1:0] state_vec;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		logic prev;
		if (k == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = state_vec[k-1];
		end
		wbps_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (cell_ctrl),
			.data_byte    (data_byte),
			.pattern_byte (pattern_q[8*k +: 8]),
			.wild         (wildcard_q[k]),
			.prev_match   (prev),
			.match_next   (next_vec[k]),
			.match_q      (state_vec[k])
		);
	end

	// result of the accepted item, no compare once the scan has reported
	logic                     hit;
	logic                     res_valid;
	logic                     res_found;
	logic [POSITION_BITS-1:0] start_pos;
	logic [63:0]              start_ext;
	logic [wbps_pkg::START_BITS-1:0] res_start;

	assign hit = accept & ~reported_q & next_vec[len_idx];
	assign start_pos = pos_q - POSITION_BITS'(len_eff - LB'(1));
	assign start_ext = 64'(start_pos);
	assign res_found = hit;
	assign res_start = hit ? start_ext[wbps_pkg::START_BITS-1:0] : '0;
	assign res_valid = hit | (accept & scan_end & ~reported_q);

	// stream position and report flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (scan_end) begin
				pos_q <= '0;
				reported_q <= 1'b0;
			end else begin
				pos_q <= pos_q + POSITION_BITS'(1);
				reported_q <= reported_q | hit;
			end
		end
	end

	// output register with skid entry
	logic                            out_vld_q;
	logic                            out_found_q;
	logic [wbps_pkg::START_BITS-1:0] out_start_q;
	logic                            skid_vld_q;
	logic                            skid_found_q;
	logic [wbps_pkg::START_BITS-1:0] skid_start_q;
	logic                            take;

	assign take = out_vld_q & ~result_stall;
	assign byte_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || take) begin
			if (skid_vld_q) begin
				out_vld_q <= 1'b1;
				skid_vld_q <= res_valid;
			end else begin
				out_vld_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			if (skid_vld_q) begin
				out_found_q <= skid_found_q;
				out_start_q <= skid_start_q;
				skid_found_q <= res_found;
				skid_start_q <= res_start;
			end else begin
				out_found_q <= res_found;
				out_start_q <= res_start;
			end
		end else if (res_valid) begin
			skid_found_q <= res_found;
			skid_start_q <= res_start;
		end
	end

	assign result_valid = out_vld_q;
	assign found = out_found_q;
	assign match_start = out_start_q;

endmodule

// File: src/wbps_cell.sv
module wbps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wbps_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]          data_byte,
	input  logic [7:0]          pattern_byte,
	input  logic                wild,
	input  logic                prev_match,
	output logic                match_next,
	output logic                match_q
);

	// prefix ending at this byte extends the neighbor's shorter prefix
	assign match_next = prev_match & (wild | (data_byte == pattern_byte));

	// prefix state, emptied at a section or scan boundary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.step) begin
			if (ctrl.clear) begin
				match_q <= 1'b0;
			end else begin
				match_q <= match_next;
			end
		end
	end

endmodule
